@@ rtl/idea_pkg.sv @@
// Shared types and helpers for the IDEA block encryption pipeline.
// Holds the request tag, the pipeline item and the split modulo-65537 multiply.
// No dependencies; used by every rtl module and the checker.
package idea_pkg;

  localparam int unsigned ROUND_COUNT = 8;
  localparam int unsigned ROUND_KEYS  = 6;
  localparam int unsigned OUT_KEYS    = 4;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_ENCRYPT = 1'b1;

  typedef struct packed {
    logic        enc;
    logic [5:0]  idx;
    logic [15:0] kv;
  } tag_t;

  typedef struct packed {
    tag_t        tag;
    logic [15:0] w0;
    logic [15:0] w1;
    logic [15:0] w2;
    logic [15:0] w3;
  } item_t;

  // Multiply modulo 65537 split in two: raw product first, folding after a register.
  typedef struct packed {
    logic [31:0] prod;
    logic        spec;
    logic [15:0] sval;
  } mm_t;

  function automatic mm_t mm_start(logic [15:0] x, logic [15:0] y);
    mm_t r;
    r.prod = 32'(x) * 32'(y);
    r.spec = (x == 16'd0) || (y == 16'd0);
    // a zero word stands for 65536: 65536 * y folds to 1 - y
    r.sval = (x == 16'd0) ? (16'd1 - y) : (16'd1 - x);
    return r;
  endfunction

  function automatic logic [15:0] mm_finish(mm_t m);
    logic [15:0] lo;
    logic [15:0] hi;
    logic [15:0] dif;
    lo  = m.prod[15:0];
    hi  = m.prod[31:16];
    dif = lo - hi;
    if (m.spec) begin
      return m.sval;
    end else if (lo >= hi) begin
      return dif;
    end else begin
      return dif + 16'd1;
    end
  endfunction

endpackage

@@ rtl/idea_if.sv @@
// Valid/ready channel interfaces for the IDEA encryption block.
// Request channel carries command and key or block fields; result channel four words.
// No dependencies.
interface idea_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [5:0]  subkey_index;
  logic [15:0] subkey_value;
  logic [15:0] in_word0;
  logic [15:0] in_word1;
  logic [15:0] in_word2;
  logic [15:0] in_word3;

  modport source (output valid, command, subkey_index, subkey_value,
                  in_word0, in_word1, in_word2, in_word3, input ready);
  modport sink   (input valid, command, subkey_index, subkey_value,
                  in_word0, in_word1, in_word2, in_word3, output ready);
endinterface

interface idea_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_word0;
  logic [15:0] out_word1;
  logic [15:0] out_word2;
  logic [15:0] out_word3;

  modport source (output valid, out_word0, out_word1, out_word2, out_word3,
                  input ready);
  modport sink   (input valid, out_word0, out_word1, out_word2, out_word3,
                  output ready);
endinterface

@@ rtl/idea_round.sv @@
// One IDEA round as four pipeline stages, with its own six subkey registers.
// Load requests passing the round entry write the subkeys that fall in its range.
// Depends on idea_pkg.
module idea_round #(
  parameter int unsigned BASE = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  idea_pkg::item_t in_item,
  output logic          out_valid,
  input  logic          out_ready,
  output idea_pkg::item_t out_item
);

  localparam logic [5:0] BaseIdx = 6'(BASE);
  localparam logic [5:0] EndIdx  = 6'(BASE + idea_pkg::ROUND_KEYS);

  typedef struct packed {
    idea_pkg::tag_t tag;
    idea_pkg::mm_t  p0;
    idea_pkg::mm_t  p3;
    logic [15:0]    b1;
    logic [15:0]    b2;
    logic [15:0]    k4;
    logic [15:0]    k5;
  } st1_t;

  typedef struct packed {
    idea_pkg::tag_t tag;
    logic [15:0]    w0;
    logic [15:0]    w3;
    logic [15:0]    b1;
    logic [15:0]    b2;
    idea_pkg::mm_t  p4;
    logic [15:0]    k5;
  } st2_t;

  typedef struct packed {
    idea_pkg::tag_t tag;
    logic [15:0]    w0;
    logic [15:0]    w3;
    logic [15:0]    b1;
    logic [15:0]    b2;
    logic [15:0]    m1;
    idea_pkg::mm_t  p5;
  } st3_t;

  logic [15:0] key_r [idea_pkg::ROUND_KEYS];
  logic        v1_r, v2_r, v3_r, v4_r;
  st1_t        s1_r, s1_nxt;
  st2_t        s2_r, s2_nxt;
  st3_t        s3_r, s3_nxt;
  idea_pkg::item_t s4_r, s4_nxt;
  logic        ld1, ld2, ld3, ld4;
  logic        key_hit;
  logic [5:0]  key_off;

  // a stage takes a new request when empty or when its content moves on
  assign ld4      = !v4_r || out_ready;
  assign ld3      = !v3_r || ld4;
  assign ld2      = !v2_r || ld3;
  assign ld1      = !v1_r || ld2;
  assign in_ready = ld1;

  assign key_off = in_item.tag.idx - BaseIdx;
  assign key_hit = (in_item.tag.enc == idea_pkg::CMD_LOAD) &&
                   (in_item.tag.idx >= BaseIdx) && (in_item.tag.idx < EndIdx);

  always_comb begin
    s1_nxt.tag = in_item.tag;
    s1_nxt.p0  = idea_pkg::mm_start(in_item.w0, key_r[0]);
    s1_nxt.p3  = idea_pkg::mm_start(in_item.w3, key_r[3]);
    s1_nxt.b1  = in_item.w1 + key_r[1];
    s1_nxt.b2  = in_item.w2 + key_r[2];
    // carry the late subkeys so a later load cannot change them under this request
    s1_nxt.k4  = key_r[4];
    s1_nxt.k5  = key_r[5];
  end

  always_comb begin
    s2_nxt.tag = s1_r.tag;
    s2_nxt.w0  = idea_pkg::mm_finish(s1_r.p0);
    s2_nxt.w3  = idea_pkg::mm_finish(s1_r.p3);
    s2_nxt.b1  = s1_r.b1;
    s2_nxt.b2  = s1_r.b2;
    s2_nxt.p4  = idea_pkg::mm_start(s1_r.b2 ^ s2_nxt.w0, s1_r.k4);
    s2_nxt.k5  = s1_r.k5;
  end

  always_comb begin
    s3_nxt.tag = s2_r.tag;
    s3_nxt.w0  = s2_r.w0;
    s3_nxt.w3  = s2_r.w3;
    s3_nxt.b1  = s2_r.b1;
    s3_nxt.b2  = s2_r.b2;
    s3_nxt.m1  = idea_pkg::mm_finish(s2_r.p4);
    s3_nxt.p5  = idea_pkg::mm_start((s2_r.w3 ^ s2_r.b1) + s3_nxt.m1, s2_r.k5);
  end

  always_comb begin
    logic [15:0] t;
    logic [15:0] m2;
    t          = idea_pkg::mm_finish(s3_r.p5);
    m2         = s3_r.m1 + t;
    s4_nxt.tag = s3_r.tag;
    s4_nxt.w0  = s3_r.w0 ^ t;
    s4_nxt.w1  = t ^ s3_r.b2;
    s4_nxt.w2  = m2 ^ s3_r.b1;
    s4_nxt.w3  = s3_r.w3 ^ m2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (ld1) begin
        v1_r <= in_valid;
      end
      if (ld2) begin
        v2_r <= v1_r;
      end
      if (ld3) begin
        v3_r <= v2_r;
      end
      if (ld4) begin
        v4_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && ld1) begin
      s1_r <= s1_nxt;
    end
    if (v1_r && ld2) begin
      s2_r <= s2_nxt;
    end
    if (v2_r && ld3) begin
      s3_r <= s3_nxt;
    end
    if (v3_r && ld4) begin
      s4_r <= s4_nxt;
    end
    if (in_valid && ld1 && key_hit) begin
      key_r[key_off[2:0]] <= in_item.tag.kv;
    end
  end

  assign out_valid = v4_r;
  assign out_item  = s4_r;

endmodule

@@ rtl/idea_out_xform.sv @@
// Output transform of IDEA in two pipeline stages, with its four subkey registers.
// Load requests end here and give no result; encrypt requests leave as four words.
// Depends on idea_pkg and idea_if.
module idea_out_xform #(
  parameter int unsigned BASE = 48
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  idea_pkg::item_t in_item,
  idea_out_if.source      res
);

  localparam logic [5:0] BaseIdx = 6'(BASE);
  localparam logic [5:0] EndIdx  = 6'(BASE + idea_pkg::OUT_KEYS);

  typedef struct packed {
    logic          enc;
    idea_pkg::mm_t p0;
    idea_pkg::mm_t p3;
    logic [15:0]   o1;
    logic [15:0]   o2;
  } xs1_t;

  logic [15:0] key_r [idea_pkg::OUT_KEYS];
  logic        v1_r, ov_r;
  xs1_t        s1_r, s1_nxt;
  logic [15:0] o0_r, o1_r, o2_r, o3_r;
  logic        ld1, ld2;
  logic        key_hit;
  logic [5:0]  key_off;

  assign ld2      = !ov_r || res.ready;
  assign ld1      = !v1_r || ld2;
  assign in_ready = ld1;

  assign key_off = in_item.tag.idx - BaseIdx;
  assign key_hit = (in_item.tag.enc == idea_pkg::CMD_LOAD) &&
                   (in_item.tag.idx >= BaseIdx) && (in_item.tag.idx < EndIdx);

  always_comb begin
    s1_nxt.enc = in_item.tag.enc;
    s1_nxt.p0  = idea_pkg::mm_start(in_item.w0, key_r[0]);
    s1_nxt.p3  = idea_pkg::mm_start(in_item.w3, key_r[3]);
    // middle words cross over in the output transform
    s1_nxt.o1  = in_item.w2 + key_r[1];
    s1_nxt.o2  = in_item.w1 + key_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (ld1) begin
        v1_r <= in_valid;
      end
      // drop load requests here
      if (ld2) begin
        ov_r <= v1_r && (s1_r.enc == idea_pkg::CMD_ENCRYPT);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && ld1) begin
      s1_r <= s1_nxt;
    end
    if (v1_r && ld2) begin
      o0_r <= idea_pkg::mm_finish(s1_r.p0);
      o1_r <= s1_r.o1;
      o2_r <= s1_r.o2;
      o3_r <= idea_pkg::mm_finish(s1_r.p3);
    end
    if (in_valid && ld1 && key_hit) begin
      key_r[key_off[1:0]] <= in_item.tag.kv;
    end
  end

  assign res.valid     = ov_r;
  assign res.out_word0 = o0_r;
  assign res.out_word1 = o1_r;
  assign res.out_word2 = o2_r;
  assign res.out_word3 = o3_r;

endmodule

@@ rtl/idea_block_encrypt_unit.sv @@
// Top level of the IDEA block encryption pipeline.
// Depends on idea_pkg, idea_if, idea_round and idea_out_xform.
//
// Usage:
//   in_ch  : requests. command = load writes subkey_value to subkey position
//            subkey_index (positions above 51 are ignored); command = encrypt
//            takes the block in_word0..in_word3. Loads give no result.
//   out_ch : one result of four words for each encrypt request, in order.
//   Subkeys live in the stage that uses them; a load travels down the pipe in
//   request order, so every encrypt sees exactly the keys loaded before it.
//   Throughput: one request per cycle while out_ch does not stall. Each round
//   pipelines its three dependent modulo-65537 multiplies, the folding of one
//   sharing a stage with the next multiply; two stages of output transform
//   follow the rounds.
//   Reset clears every valid bit; subkeys hold no defined value until loaded.
//   When out_ch stalls the results hold and requests keep entering until the
//   pipe has no empty stage left; nothing is lost or repeated.
module idea_block_encrypt_unit #(
  parameter int unsigned ROUND_COUNT = idea_pkg::ROUND_COUNT
) (
  input  logic      clk,
  input  logic      rst_n,
  idea_in_if.sink   in_ch,
  idea_out_if.source out_ch
);

  idea_pkg::item_t        item_w [ROUND_COUNT+1];
  logic [ROUND_COUNT:0]   vld_w;
  logic [ROUND_COUNT:0]   rdy_w;

  assign vld_w[0]              = in_ch.valid;
  assign in_ch.ready           = rdy_w[0];
  assign item_w[0].tag.enc     = in_ch.command;
  assign item_w[0].tag.idx     = in_ch.subkey_index;
  assign item_w[0].tag.kv      = in_ch.subkey_value;
  assign item_w[0].w0          = in_ch.in_word0;
  assign item_w[0].w1          = in_ch.in_word1;
  assign item_w[0].w2          = in_ch.in_word2;
  assign item_w[0].w3          = in_ch.in_word3;

  for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
    idea_round #(
      .BASE(idea_pkg::ROUND_KEYS * r)
    ) u_round (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (vld_w[r]),
      .in_ready (rdy_w[r]),
      .in_item  (item_w[r]),
      .out_valid(vld_w[r+1]),
      .out_ready(rdy_w[r+1]),
      .out_item (item_w[r+1])
    );
  end

  idea_out_xform #(
    .BASE(idea_pkg::ROUND_KEYS * ROUND_COUNT)
  ) u_out_xform (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(vld_w[ROUND_COUNT]),
    .in_ready(rdy_w[ROUND_COUNT]),
    .in_item (item_w[ROUND_COUNT]),
    .res     (out_ch)
  );

endmodule

@@ rtl/idea_chk.sv @@
// Port-level checker for idea_block_encrypt_unit, attached by bind.
// Tracks encrypt requests in flight against delivered results.
// Depends on idea_pkg.
module idea_chk #(
  parameter int unsigned ROUND_COUNT = idea_pkg::ROUND_COUNT
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_command,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_word0,
  input logic [15:0] out_word1,
  input logic [15:0] out_word2,
  input logic [15:0] out_word3
);

  localparam int unsigned Depth = 4 * ROUND_COUNT + 2;
  localparam int unsigned CntW  = $clog2(Depth + 2);

  logic [CntW-1:0] pending_r, pending_nxt;
  logic            enc_in, res_out;

  assign enc_in  = in_valid && in_ready && (in_command == idea_pkg::CMD_ENCRYPT);
  assign res_out = out_valid && out_ready;

  always_comb begin
    pending_nxt = pending_r;
    if (enc_in && !res_out) begin
      pending_nxt = pending_r + 1'b1;
    end else if (!enc_in && res_out) begin
      pending_nxt = pending_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable(out_word0) && $stable(out_word1) &&
      $stable(out_word2) && $stable(out_word3))
    else $error("stalled result changed or dropped");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != '0)
    else $error("result without an encrypt request in flight");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= CntW'(Depth))
    else $error("more encrypt requests in flight than pipeline stages");

endmodule

bind idea_block_encrypt_unit idea_chk #(
  .ROUND_COUNT(ROUND_COUNT)
) u_idea_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_command(in_ch.command),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_word0 (out_ch.out_word0),
  .out_word1 (out_ch.out_word1),
  .out_word2 (out_ch.out_word2),
  .out_word3 (out_ch.out_word3)
);
